// ===== hw/rtl/rcs_pkg.sv =====
// rcs_pkg: constants, action codes and the percent scaling function
// shared by the rgb cross-fade stepper; depends on nothing
package rcs_pkg;

    localparam int NUM_CH    = 3;
    localparam int LVL_W     = 8;
    localparam int PCT_W     = 7;
    localparam int ACT_W     = 2;
    localparam int TGT_W     = 9;
    localparam int DIFF_W    = TGT_W + 1;
    localparam int FADE_SPAN = 1020;
    localparam int SPAN_W    = $clog2(FADE_SPAN + 1);
    localparam int CNT_W     = $clog2(SPAN_W);
    localparam int CH_W      = $clog2(NUM_CH);

    localparam logic [ACT_W-1:0] ACT_START = 2'd0;
    localparam logic [ACT_W-1:0] ACT_TICK  = 2'd1;
    localparam logic [ACT_W-1:0] ACT_ABORT = 2'd2;

    localparam logic [LVL_W-1:0]  LVL_MAX   = 8'd255;
    localparam logic [PCT_W-1:0]  PCT_MAX   = 7'd100;
    localparam logic [SPAN_W-1:0] SPAN_CONST = SPAN_W'(FADE_SPAN);

    // pct * 256 / 100 == pct * 64 / 25, done as multiply by 64 * round(2^17 / 25)
    localparam int PROD_W   = 26;
    localparam int SCALE_SH = 17;
    localparam logic [PROD_W-1:0] SCALE_MUL = 26'd335552;

    function automatic logic [TGT_W-1:0] scale_pct(input logic [PCT_W-1:0] pct);
        logic [PCT_W-1:0]  sat;
        logic [PROD_W-1:0] prod;
        sat  = (pct > PCT_MAX) ? PCT_MAX : pct;
        prod = PROD_W'(sat) * SCALE_MUL;
        return prod[SCALE_SH +: TGT_W];
    endfunction

endpackage

// ===== hw/rtl/rgb_crossfade_stepper.sv =====
// rgb_crossfade_stepper: three-channel linear led cross-fader with a shared
// serial divider for the per-channel step sizes; depends on rcs_pkg
//
//  channel   signals                                     role
//  item      item_valid/item_ready, action, target_*     start, tick or abort
//  result    result_valid/result_ready, *_level,         levels and fade flags
//            fading, fade_done                           after each item
//
// tick, abort and unknown actions are handled directly in ST_IDLE; a start runs
// ST_LOAD and ST_RUN once per channel: one restoring division per channel, one quotient bit per cycle.
// the result register frees the item side: a new item is taken while a result
// waits, as long as that result is taken in the same cycle or the slot is empty.
// reset (asynchronous) clears levels, steps, tick count and all control state.
module rgb_crossfade_stepper (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       item_valid,
    output logic                       item_ready,
    input  logic [rcs_pkg::ACT_W-1:0]  action,
    input  logic [rcs_pkg::PCT_W-1:0]  target_red_pct,
    input  logic [rcs_pkg::PCT_W-1:0]  target_green_pct,
    input  logic [rcs_pkg::PCT_W-1:0]  target_blue_pct,
    output logic                       result_valid,
    input  logic                       result_ready,
    output logic [rcs_pkg::LVL_W-1:0]  red_level,
    output logic [rcs_pkg::LVL_W-1:0]  green_level,
    output logic [rcs_pkg::LVL_W-1:0]  blue_level,
    output logic                       fading,
    output logic                       fade_done
);
    import rcs_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_LOAD = 2'd1;
    localparam logic [1:0] ST_RUN  = 2'd2;

    logic [1:0]         state_reg, state_next;
    logic [CH_W-1:0]    ch_reg, ch_next;
    logic [CNT_W-1:0]   bit_reg, bit_next;

    logic [TGT_W-1:0]   tgt_reg   [NUM_CH];
    logic [TGT_W-1:0]   tgt_next  [NUM_CH];
    logic [LVL_W-1:0]   lvl_reg   [NUM_CH];
    logic [LVL_W-1:0]   lvl_next  [NUM_CH];
    logic [LVL_W-1:0]   start_reg [NUM_CH];
    logic [LVL_W-1:0]   start_next[NUM_CH];
    logic [SPAN_W-1:0]  mag_reg   [NUM_CH];
    logic [SPAN_W-1:0]  mag_next  [NUM_CH];
    logic               down_reg  [NUM_CH];
    logic               down_next [NUM_CH];
    logic [SPAN_W-1:0]  phase_reg [NUM_CH];
    logic [SPAN_W-1:0]  phase_next[NUM_CH];

    logic [SPAN_W-1:0]  tick_reg, tick_next;
    logic               fade_reg, fade_next;
    logic               dark_reg, dark_next;

    logic [TGT_W-1:0]   den_reg, den_next;
    logic [TGT_W-1:0]   rem_reg, rem_next;
    logic [SPAN_W-1:0]  quo_reg, quo_next;
    logic               neg_reg, neg_next;
    logic               zero_reg, zero_next;

    logic               res_valid_reg, res_valid_next;
    logic [LVL_W-1:0]   res_lvl_reg [NUM_CH];
    logic [LVL_W-1:0]   res_lvl_next[NUM_CH];
    logic               res_fade_reg, res_fade_next;
    logic               res_done_reg, res_done_next;

    logic               accept;
    logic [DIFF_W-1:0]  diff;
    logic [DIFF_W-1:0]  diff_abs;
    logic [DIFF_W-1:0]  part;
    logic               ge;
    logic [DIFF_W-1:0]  part_sub;
    logic [SPAN_W-1:0]  quo_shift;
    logic               hit;
    logic               done;

    assign item_ready = (state_reg == ST_IDLE) && (!res_valid_reg || result_ready);
    assign accept     = item_valid && item_ready;

    // divider datapath
    assign diff      = {1'b0, tgt_reg[ch_reg]} - {2'b00, start_reg[ch_reg]};
    assign diff_abs  = diff[DIFF_W-1] ? (~diff + DIFF_W'(1)) : diff;
    assign part      = {rem_reg, quo_reg[SPAN_W-1]};
    assign ge        = part >= {1'b0, den_reg};
    assign part_sub  = part - {1'b0, den_reg};
    assign quo_shift = {quo_reg[SPAN_W-2:0], ge};

    always_comb
    begin
        state_next     = state_reg;
        ch_next        = ch_reg;
        bit_next       = bit_reg;
        tick_next      = tick_reg;
        fade_next      = fade_reg;
        dark_next      = dark_reg;
        den_next       = den_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        neg_next       = neg_reg;
        zero_next      = zero_reg;
        res_fade_next  = res_fade_reg;
        res_done_next  = res_done_reg;
        res_valid_next = res_valid_reg && !result_ready;
        done           = 1'b0;
        hit            = 1'b0;
        for (int c = 0; c < NUM_CH; c++)
        begin
            tgt_next[c]     = tgt_reg[c];
            lvl_next[c]     = lvl_reg[c];
            start_next[c]   = start_reg[c];
            mag_next[c]     = mag_reg[c];
            down_next[c]    = down_reg[c];
            phase_next[c]   = phase_reg[c];
            res_lvl_next[c] = res_lvl_reg[c];
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    priority if (action == ACT_START)
                    begin
                        tgt_next[0] = scale_pct(target_red_pct);
                        tgt_next[1] = scale_pct(target_green_pct);
                        tgt_next[2] = scale_pct(target_blue_pct);
                        if (dark_reg)
                        begin
                            for (int c = 0; c < NUM_CH; c++)
                            begin
                                lvl_next[c]   = '0;
                                start_next[c] = '0;
                            end
                            dark_next = 1'b0;
                        end
                        for (int c = 0; c < NUM_CH; c++)
                            phase_next[c] = '0;
                        tick_next  = '0;
                        fade_next  = 1'b1;
                        ch_next    = '0;
                        state_next = ST_LOAD;
                    end
                    else if (action == ACT_TICK)
                    begin
                        if (fade_reg)
                        begin
                            for (int c = 0; c < NUM_CH; c++)
                            begin
                                hit = (mag_reg[c] != '0) && (phase_reg[c] == '0);
                                if (mag_reg[c] != '0)
                                    phase_next[c] = hit ? (mag_reg[c] - SPAN_W'(1))
                                                        : (phase_reg[c] - SPAN_W'(1));
                                if (hit)
                                begin
                                    if (down_reg[c])
                                        lvl_next[c] = (lvl_reg[c] == '0) ? '0
                                                    : lvl_reg[c] - LVL_W'(1);
                                    else
                                        lvl_next[c] = (lvl_reg[c] == LVL_MAX) ? LVL_MAX
                                                    : lvl_reg[c] + LVL_W'(1);
                                end
                            end
                            if (tick_reg >= SPAN_CONST)
                            begin
                                done      = 1'b1;
                                fade_next = 1'b0;
                                for (int c = 0; c < NUM_CH; c++)
                                    start_next[c] = lvl_next[c];
                            end
                            else
                            begin
                                tick_next = tick_reg + SPAN_W'(1);
                            end
                        end
                    end
                    else if (action == ACT_ABORT)
                    begin
                        fade_next = 1'b0;
                        dark_next = 1'b1;
                    end
                    else
                    begin
                        fade_next = fade_reg;
                    end

                    res_valid_next = 1'b1;
                    res_fade_next  = fade_next;
                    res_done_next  = done;
                    for (int c = 0; c < NUM_CH; c++)
                        res_lvl_next[c] = lvl_next[c];
                end
            end

            ST_LOAD:
            begin
                den_next   = diff_abs[TGT_W-1:0];
                neg_next   = diff[DIFF_W-1];
                zero_next  = (diff == '0);
                rem_next   = '0;
                quo_next   = SPAN_CONST;
                bit_next   = '0;
                state_next = ST_RUN;
            end

            ST_RUN:
            begin
                rem_next = ge ? part_sub[TGT_W-1:0] : part[TGT_W-1:0];
                quo_next = quo_shift;
                bit_next = bit_reg + CNT_W'(1);
                if (bit_reg == CNT_W'(SPAN_W - 1))
                begin
                    mag_next[ch_reg]  = zero_reg ? '0 : quo_shift;
                    down_next[ch_reg] = neg_reg;
                    if (ch_reg == CH_W'(NUM_CH - 1))
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        ch_next    = ch_reg + CH_W'(1);
                        state_next = ST_LOAD;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ch_reg        <= '0;
            bit_reg       <= '0;
            tick_reg      <= '0;
            fade_reg      <= 1'b0;
            dark_reg      <= 1'b0;
            res_valid_reg <= 1'b0;
            for (int c = 0; c < NUM_CH; c++)
            begin
                lvl_reg[c]   <= '0;
                start_reg[c] <= '0;
                mag_reg[c]   <= '0;
                down_reg[c]  <= 1'b0;
                phase_reg[c] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            ch_reg        <= ch_next;
            bit_reg       <= bit_next;
            tick_reg      <= tick_next;
            fade_reg      <= fade_next;
            dark_reg      <= dark_next;
            res_valid_reg <= res_valid_next;
            for (int c = 0; c < NUM_CH; c++)
            begin
                lvl_reg[c]   <= lvl_next[c];
                start_reg[c] <= start_next[c];
                mag_reg[c]   <= mag_next[c];
                down_reg[c]  <= down_next[c];
                phase_reg[c] <= phase_next[c];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        den_reg      <= den_next;
        rem_reg      <= rem_next;
        quo_reg      <= quo_next;
        neg_reg      <= neg_next;
        zero_reg     <= zero_next;
        res_fade_reg <= res_fade_next;
        res_done_reg <= res_done_next;
        for (int c = 0; c < NUM_CH; c++)
        begin
            tgt_reg[c]     <= tgt_next[c];
            res_lvl_reg[c] <= res_lvl_next[c];
        end
    end

    assign result_valid = res_valid_reg;
    assign red_level    = res_lvl_reg[0];
    assign green_level  = res_lvl_reg[1];
    assign blue_level   = res_lvl_reg[2];
    assign fading       = res_fade_reg;
    assign fade_done    = res_done_reg;

    a_start_divides: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (action == ACT_START) |=> state_reg == ST_LOAD)
        else $error("start item did not launch the step division");

    a_busy_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != ST_IDLE |-> !item_ready)
        else $error("item taken while the divider is busy");

    a_tick_bound: assert property (@(posedge clk) disable iff (!rst_n)
        tick_reg <= SPAN_CONST)
        else $error("tick count ran past the fade span");

    a_done_ends_fade: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && fade_done |-> !fading && !fade_reg)
        else $error("fade flagged done but still running");

    a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg[0] == '0 || phase_reg[0] < mag_reg[0]) &&
        (phase_reg[1] == '0 || phase_reg[1] < mag_reg[1]) &&
        (phase_reg[2] == '0 || phase_reg[2] < mag_reg[2]))
        else $error("step phase counter outside its step size");

endmodule

// ===== tb/tb_rgb_crossfade_stepper.sv =====
`timescale 1ns / 100ps
// tb_rgb_crossfade_stepper: self-checking testbench for the rgb cross-fade stepper;
// predicts levels and fade flags for every item and checks each result in order
// depends on rcs_pkg and rgb_crossfade_stepper
module tb_rgb_crossfade_stepper;
    import rcs_pkg::*;

    localparam logic [ACT_W-1:0] ACT_IGNORED = 2'd3;
    localparam int TGT_SCALE      = 256;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int LONG_HOLD      = 300;
    localparam int DRAIN_CYCLES   = 100;
    localparam int ITEM_TARGET    = 1650;

    typedef struct packed {
        logic [LVL_W-1:0] red;
        logic [LVL_W-1:0] green;
        logic [LVL_W-1:0] blue;
        logic             fading;
        logic             done;
    } level_report_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             item_valid = 1'b0;
    logic             item_ready;
    logic [ACT_W-1:0] action = ACT_TICK;
    logic [PCT_W-1:0] target_red_pct = '0;
    logic [PCT_W-1:0] target_green_pct = '0;
    logic [PCT_W-1:0] target_blue_pct = '0;
    logic             result_valid;
    logic             result_ready = 1'b0;
    logic [LVL_W-1:0] red_level;
    logic [LVL_W-1:0] green_level;
    logic [LVL_W-1:0] blue_level;
    logic             fading;
    logic             fade_done;

    // predicted fader state
    logic [LVL_W-1:0] lvl [NUM_CH];
    logic [LVL_W-1:0] base_lvl [NUM_CH];
    int               step_len [NUM_CH];
    int               tick_pos;
    bit               fade_on;
    bit               go_dark;

    level_report_t    expected_levels_q [$];
    level_report_t    want;
    int               err_cnt;
    int               counted_items;
    int               idle_cycles;
    int               hold_left;
    int               ready_roll;
    bit               no_gaps;
    bit               long_hold_req;

    rgb_crossfade_stepper u_top (.*);

    always #5 clk = ~clk;

    function automatic int pct_to_target(input logic [PCT_W-1:0] pct);
        int p;
        p = (pct > PCT_MAX) ? int'(PCT_MAX) : int'(pct);
        return (p * TGT_SCALE) / int'(PCT_MAX);
    endfunction

    function automatic void predict_levels(input logic [ACT_W-1:0] act,
                                           input logic [PCT_W-1:0] pr, pg, pb);
        int            tgt [NUM_CH];
        int            diff;
        int            v;
        int            mag;
        int            c;
        bit            done;
        level_report_t rep;
        done = 1'b0;
        tgt[0] = pct_to_target(pr);
        tgt[1] = pct_to_target(pg);
        tgt[2] = pct_to_target(pb);
        case (act)
            ACT_START: begin
                if (go_dark) begin
                    for (c = 0; c < NUM_CH; c++) begin
                        lvl[c] = '0;
                        base_lvl[c] = '0;
                    end
                    go_dark = 1'b0;
                end
                for (c = 0; c < NUM_CH; c++) begin
                    diff = tgt[c] - int'(base_lvl[c]);
                    step_len[c] = (diff != 0) ? FADE_SPAN / diff : 0;
                end
                tick_pos = 0;
                fade_on = 1'b1;
            end
            ACT_TICK: begin
                if (fade_on) begin
                    for (c = 0; c < NUM_CH; c++) begin
                        v = int'(lvl[c]);
                        if (step_len[c] != 0) begin
                            mag = (step_len[c] < 0) ? -step_len[c] : step_len[c];
                            if (tick_pos % mag == 0)
                                v += (step_len[c] > 0) ? 1 : -1;
                        end
                        if (v > int'(LVL_MAX))
                            v = int'(LVL_MAX);
                        else if (v < 0)
                            v = 0;
                        lvl[c] = LVL_W'(v);
                    end
                    if (tick_pos >= FADE_SPAN) begin
                        done = 1'b1;
                        fade_on = 1'b0;
                        for (c = 0; c < NUM_CH; c++)
                            base_lvl[c] = lvl[c];
                    end else begin
                        tick_pos++;
                    end
                end
            end
            ACT_ABORT: begin
                fade_on = 1'b0;
                go_dark = 1'b1;
            end
            default: ;
        endcase
        rep.red = lvl[0];
        rep.green = lvl[1];
        rep.blue = lvl[2];
        rep.fading = fade_on;
        rep.done = done;
        expected_levels_q.push_back(rep);
    endfunction

    function automatic void check_field(input string name, input int exp_val,
                                        input int got_val);
        if (exp_val != got_val) begin
            $error("%s mismatch: expected %0d, actual %0d", name, exp_val, got_val);
            err_cnt++;
        end
    endfunction

    // results are checked before the item taken at the same edge is predicted
    always @(posedge clk) begin
        if (rst_n) begin
            if (result_valid && result_ready) begin
                if (expected_levels_q.size() == 0) begin
                    $error("result with no item waiting: red %0d green %0d blue %0d",
                           red_level, green_level, blue_level);
                    err_cnt++;
                end else begin
                    want = expected_levels_q.pop_front();
                    check_field("red_level", want.red, red_level);
                    check_field("green_level", want.green, green_level);
                    check_field("blue_level", want.blue, blue_level);
                    check_field("fading", want.fading, fading);
                    check_field("fade_done", want.done, fade_done);
                end
            end
            if (item_valid && item_ready) begin
                if (action == ACT_START || action == ACT_ABORT
                    || (action == ACT_TICK && fade_on))
                    counted_items++;
                predict_levels(action, target_red_pct, target_green_pct, target_blue_pct);
            end
        end
    end

    always @(posedge clk) begin
        if ((item_valid && item_ready) || (result_valid && result_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // result side stalls
    always @(negedge clk) begin
        if (hold_left > 0) begin
            hold_left--;
            result_ready <= 1'b0;
        end else if (long_hold_req) begin
            long_hold_req = 1'b0;
            hold_left = LONG_HOLD;
            result_ready <= 1'b0;
        end else if (no_gaps) begin
            result_ready <= 1'b1;
        end else begin
            ready_roll = $urandom_range(0, 99);
            if (ready_roll < 65) begin
                result_ready <= 1'b1;
            end else begin
                result_ready <= 1'b0;
                hold_left = (ready_roll < 95) ? $urandom_range(0, 2) : $urandom_range(5, 40);
            end
        end
    end

    function automatic int pick_gap();
        int r;
        if (no_gaps)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(6, 40);
    endfunction

    function automatic logic [PCT_W-1:0] rand_pct();
        if ($urandom_range(0, 99) < 85)
            return PCT_W'($urandom_range(0, 100));
        return PCT_W'($urandom_range(101, 127));
    endfunction

    // called and returns at a falling edge
    task automatic send_item(input logic [ACT_W-1:0] act,
                             input logic [PCT_W-1:0] pr, pg, pb);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            item_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        item_valid <= 1'b1;
        action <= act;
        target_red_pct <= pr;
        target_green_pct <= pg;
        target_blue_pct <= pb;
        do
            @(posedge clk);
        while (!item_ready);
        @(negedge clk);
    endtask

    task automatic send_tick();
        send_item(ACT_TICK, rand_pct(), rand_pct(), rand_pct());
    endtask

    task automatic test_directed();
        no_gaps = 1'b0;
        send_item(ACT_TICK, 0, 0, 0);
        send_item(ACT_IGNORED, 127, 127, 127);
        send_item(ACT_ABORT, 0, 0, 0);
        send_item(ACT_START, 127, 0, PCT_MAX);
        repeat (4) send_item(ACT_TICK, 0, 0, 0);
        // restart in the middle of a fade
        send_item(ACT_START, 50, 101, 1);
        repeat (4) send_item(ACT_TICK, 127, 127, 127);
        send_item(ACT_ABORT, 127, 127, 127);
        send_item(ACT_TICK, 0, 0, 0);
        send_item(ACT_IGNORED, 85, 42, 21);
        send_item(ACT_START, 0, 0, 0);
        repeat (3) send_item(ACT_TICK, 0, 0, 0);
        send_item(ACT_START, 64, PCT_MAX, 0);
        send_item(ACT_TICK, 0, 0, 0);
    endtask

    // one fade run to completion, one channel into the upper clamp
    task automatic test_full_fade();
        int i;
        send_item(ACT_START, PCT_W'($urandom_range(100, 127)), rand_pct(), rand_pct());
        for (i = 0; i <= FADE_SPAN; i++) begin
            no_gaps = (i >= 300 && i < 500);
            send_tick();
        end
        no_gaps = 1'b0;
        // fade red and blue back down from the completed levels
        send_item(ACT_START, PCT_W'($urandom_range(0, 20)), rand_pct(), 0);
        repeat (30) send_tick();
    endtask

    task automatic test_backpressure();
        no_gaps = 1'b1;
        long_hold_req = 1'b1;
        send_item(ACT_START, rand_pct(), rand_pct(), rand_pct());
        repeat (20) send_tick();
        no_gaps = 1'b0;
    endtask

    task automatic test_random_mix();
        int seq_kind;
        int n_ticks;
        while (counted_items < ITEM_TARGET) begin
            seq_kind = $urandom_range(0, 99);
            no_gaps = ($urandom_range(0, 4) == 0);
            if (seq_kind < 70) begin
                send_item(ACT_START, rand_pct(), rand_pct(), rand_pct());
                n_ticks = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                      : $urandom_range(1, 40);
                repeat (n_ticks) send_tick();
                if ($urandom_range(0, 4) == 0)
                    send_item(ACT_ABORT, rand_pct(), rand_pct(), rand_pct());
            end else begin
                repeat ($urandom_range(1, 6))
                    send_item(ACT_W'($urandom_range(0, 3)), rand_pct(), rand_pct(),
                              rand_pct());
            end
        end
        no_gaps = 1'b0;
    endtask

    initial begin
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_full_fade();
        test_backpressure();
        test_random_mix();
        item_valid <= 1'b0;
        while (expected_levels_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (err_cnt == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/rcs_pkg.sv
hw/rtl/rgb_crossfade_stepper.sv
tb/tb_rgb_crossfade_stepper.sv
